/* rtl/r16x_pkg.sv */
// Shared types and constants of the 16-bit execute unit.
`default_nettype none

package r16x_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int NUM_REGS      = 8;
  localparam int REG_W         = 16;
  localparam int IDX_W         = 3;
  localparam int IMM_W         = 8;
  localparam int CMD_W         = 5;

  typedef enum logic [CMD_W-1:0] {
    OP_AND    = 5'd0,
    OP_OR     = 5'd1,
    OP_XOR    = 5'd2,
    OP_NOT    = 5'd3,
    OP_ADD    = 5'd4,
    OP_SUB    = 5'd5,
    OP_SHL    = 5'd6,
    OP_CMPLT  = 5'd7,
    OP_CMPLE  = 5'd8,
    OP_CMPEQ  = 5'd9,
    OP_CMPLTU = 5'd10,
    OP_CMPLEU = 5'd11,
    OP_ADDI   = 5'd12,
    OP_LD     = 5'd13,
    OP_ST     = 5'd14,
    OP_LDB    = 5'd15,
    OP_STB    = 5'd16,
    OP_BZ     = 5'd17,
    OP_BNZ    = 5'd18,
    OP_MOVI   = 5'd19,
    OP_IN     = 5'd20,
    OP_OUT    = 5'd21
  } op_t;

  typedef enum logic [2:0] {
    K_ALU    = 3'd0,
    K_LOAD   = 3'd1,
    K_STORE  = 3'd2,
    K_BRANCH = 3'd3,
    K_OUT    = 3'd4,
    K_NOP    = 3'd5
  } kind_t;

  typedef struct packed {
    op_t              op;
    kind_t            kind;
    logic             rf_we;
    logic [IDX_W-1:0] rd;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    logic [IMM_W-1:0] imm;
    logic [REG_W-1:0] inval;
  } dec_t;

endpackage

`default_nettype wire

/* rtl/r16x_front.sv */
// Front end: accepts instruction words, classifies them and queues them for the back end.
`default_nettype none

module r16x_front (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [r16x_pkg::CMD_W-1:0]    in_command,
  input  wire  [r16x_pkg::IDX_W-1:0]    in_dest_index,
  input  wire  [r16x_pkg::IDX_W-1:0]    in_src_a_index,
  input  wire  [r16x_pkg::IDX_W-1:0]    in_src_b_index,
  input  wire  signed [r16x_pkg::IMM_W-1:0] in_immediate,
  input  wire  signed [r16x_pkg::REG_W-1:0] in_in_value,
  input  wire                           hold,
  output r16x_pkg::dec_t                head,
  output logic                          head_vld,
  input  wire                           pop
);
  import r16x_pkg::*;

  dec_t       dec;
  dec_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;

  always_comb begin
    dec.op    = OP_AND;
    dec.kind  = K_NOP;
    dec.rf_we = 1'b0;
    dec.rd    = in_dest_index;
    dec.ra    = in_src_a_index;
    dec.rb    = in_src_b_index;
    dec.imm   = in_immediate;
    dec.inval = in_in_value;
    if (in_command <= OP_OUT) begin
      dec.op = op_t'(in_command);
      unique case (dec.op) inside
        OP_LD, OP_LDB: begin
          dec.kind = K_LOAD;
        end
        OP_ST, OP_STB: begin
          dec.kind = K_STORE;
        end
        OP_BZ, OP_BNZ: begin
          dec.kind = K_BRANCH;
        end
        OP_OUT: begin
          dec.kind = K_OUT;
        end
        default: begin
          dec.kind  = K_ALU;
          dec.rf_we = 1'b1;
        end
      endcase
    end
  end

  assign in_stall = (cnt_r == 2'd2) || hold;
  assign push     = in_valid && !in_stall;
  assign head     = q_r[rd_ptr_r];
  assign head_vld = (cnt_r != 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

/* rtl/r16x_dmem.sv */
// Byte-wide data memory with one access port and a clearing pass after reset.
`default_nettype none

module r16x_dmem #(
  parameter int MEM_BYTES = r16x_pkg::MEM_BYTES_DEF,
  parameter int AW        = $clog2(MEM_BYTES)
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           we,
  input  wire  [AW-1:0] addr,
  input  wire  [7:0]    wdata,
  output logic [7:0]    rdata,
  output logic          busy
);
  import r16x_pkg::*;

  logic [7:0]    mem [MEM_BYTES];
  logic [7:0]    rdata_r;
  logic [AW-1:0] clr_cnt_r;
  logic          busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(MEM_BYTES - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_cnt_r] <= 8'd0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

`default_nettype wire

/* rtl/r16x_back.sv */
// Back end: register file, ALU, address forming, load/store sequencing and result register.
`default_nettype none

module r16x_back #(
  parameter int MEM_BYTES = r16x_pkg::MEM_BYTES_DEF,
  parameter int AW        = $clog2(MEM_BYTES)
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  r16x_pkg::dec_t                    head,
  input  wire                               head_vld,
  output logic                              pop,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_addr,
  output logic [7:0]                        mem_wdata,
  input  wire  [7:0]                        mem_rdata,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              out_branch_taken,
  output logic signed [8:0]                 out_branch_offset,
  output logic                              out_out_valid,
  output logic signed [r16x_pkg::REG_W-1:0] out_out_value
);
  import r16x_pkg::*;

  localparam bit POW2 = (MEM_BYTES == (1 << AW));

  typedef enum logic [5:0] {
    S_FETCH = 6'b000001,
    S_AGEN  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_ST2   = 6'b001000,
    S_LD1   = 6'b010000,
    S_LD2   = 6'b100000
  } state_t;

  state_t           state_r;
  state_t           state_nxt;
  dec_t             ins_r;
  logic [REG_W-1:0] va_r;
  logic [REG_W-1:0] vb_r;
  logic [7:0]       lo_r;
  logic [AW-1:0]    a1_r;
  logic [REG_W-1:0] rf [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_r;

  logic             exec_go;
  logic             is_mem_head;
  logic [REG_W-1:0] imm16;
  logic [REG_W-1:0] ea16;
  logic [AW-1:0]    ea;
  logic [AW-1:0]    ea_nx;
  logic [REG_W-1:0] alu_res;
  logic [REG_W-1:0] sh_mag;
  logic             rf_we;
  logic [IDX_W-1:0] rf_wa;
  logic [REG_W-1:0] rf_wd;
  logic             br_taken;

  logic             out_vld_r;
  logic             br_taken_r;
  logic [8:0]       br_off_r;
  logic             oval_vld_r;
  logic [REG_W-1:0] oval_r;

  assign imm16 = {{(REG_W - IMM_W){ins_r.imm[IMM_W-1]}}, ins_r.imm};
  assign ea16  = va_r + imm16;

  generate
    if (POW2) begin : g_pow2
      assign ea = ea16[AW-1:0];
    end else begin : g_mod
      localparam logic [24:0] RECIP = 25'((64'd1 << 32) / MEM_BYTES);
      logic [40:0] prod;
      logic [8:0]  quo_r;
      logic [16:0] rem0;
      logic [16:0] rem1;

      assign prod = 41'(ea16) * 41'(RECIP);

      always_ff @(posedge clk) begin
        quo_r <= prod[40:32];
      end

      assign rem0 = 17'(ea16) - 17'(quo_r) * 17'(MEM_BYTES);
      assign rem1 = (rem0 >= 17'(MEM_BYTES)) ? rem0 - 17'(MEM_BYTES) : rem0;
      assign ea   = rem1[AW-1:0];
    end
  endgenerate

  assign ea_nx = (ea == AW'(MEM_BYTES - 1)) ? '0 : ea + AW'(1);

  assign pop         = (state_r == S_FETCH) && head_vld;
  assign exec_go     = (state_r == S_EXEC) && (!out_vld_r || !out_stall);
  assign is_mem_head = (head.kind == K_LOAD) || (head.kind == K_STORE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FETCH: begin
        if (head_vld) begin
          state_nxt = (!POW2 && is_mem_head) ? S_AGEN : S_EXEC;
        end
      end
      S_AGEN: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          if (ins_r.op == OP_ST) begin
            state_nxt = S_ST2;
          end else if (ins_r.kind == K_LOAD) begin
            state_nxt = S_LD1;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_ST2: begin
        state_nxt = S_FETCH;
      end
      S_LD1: begin
        state_nxt = (ins_r.op == OP_LD) ? S_LD2 : S_FETCH;
      end
      S_LD2: begin
        state_nxt = S_FETCH;
      end
      default: begin
        state_nxt = S_FETCH;
      end
    endcase
  end

  always_comb begin
    sh_mag  = 16'(~vb_r + 16'd1);
    alu_res = '0;
    case (ins_r.op)
      OP_AND:    alu_res = va_r & vb_r;
      OP_OR:     alu_res = va_r | vb_r;
      OP_XOR:    alu_res = va_r ^ vb_r;
      OP_NOT:    alu_res = ~va_r;
      OP_ADD:    alu_res = va_r + vb_r;
      OP_SUB:    alu_res = va_r - vb_r;
      OP_SHL: begin
        if (!vb_r[REG_W-1]) begin
          alu_res = (vb_r[REG_W-1:4] != '0) ? '0 : va_r << vb_r[3:0];
        end else begin
          alu_res = (sh_mag[REG_W-1:4] != '0) ? '0 : va_r >> sh_mag[3:0];
        end
      end
      OP_CMPLT:  alu_res = {15'd0, $signed(va_r) < $signed(vb_r)};
      OP_CMPLE:  alu_res = {15'd0, $signed(va_r) <= $signed(vb_r)};
      OP_CMPEQ:  alu_res = {15'd0, va_r == vb_r};
      OP_CMPLTU: alu_res = {15'd0, va_r < vb_r};
      OP_CMPLEU: alu_res = {15'd0, va_r <= vb_r};
      OP_ADDI:   alu_res = ea16;
      OP_MOVI:   alu_res = imm16;
      OP_IN:     alu_res = ins_r.inval;
      default:   alu_res = '0;
    endcase
  end

  assign br_taken = (ins_r.kind == K_BRANCH) &&
                    ((ins_r.op == OP_BZ) == (va_r == '0));

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ea;
    mem_wdata = vb_r[7:0];
    if (exec_go && (ins_r.kind == K_STORE)) begin
      mem_we = 1'b1;
    end
    if (state_r == S_ST2) begin
      mem_we    = 1'b1;
      mem_addr  = a1_r;
      mem_wdata = vb_r[15:8];
    end
    if (state_r == S_LD1) begin
      mem_addr = a1_r;
    end
  end

  always_comb begin
    rf_we = 1'b0;
    rf_wa = ins_r.rd;
    rf_wd = alu_res;
    if (exec_go && ins_r.rf_we) begin
      rf_we = 1'b1;
    end
    if ((state_r == S_LD1) && (ins_r.op == OP_LDB)) begin
      rf_we = 1'b1;
      rf_wd = {{8{mem_rdata[7]}}, mem_rdata};
    end
    if (state_r == S_LD2) begin
      rf_we = 1'b1;
      rf_wd = {mem_rdata, lo_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_FETCH;
      rf_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (rf_we) begin
        rf_vld_r[rf_wa] <= 1'b1;
      end
      if (exec_go) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ins_r <= head;
      va_r  <= rf_vld_r[head.ra] ? rf[head.ra] : '0;
      vb_r  <= rf_vld_r[head.rb] ? rf[head.rb] : '0;
    end
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (state_r == S_EXEC) begin
      a1_r <= ea_nx;
    end
    if (state_r == S_LD1) begin
      lo_r <= mem_rdata;
    end
    if (exec_go) begin
      br_taken_r <= br_taken;
      br_off_r   <= br_taken ? {ins_r.imm, 1'b0} : 9'd0;
      oval_vld_r <= (ins_r.kind == K_OUT);
      oval_r     <= (ins_r.kind == K_OUT) ? va_r : '0;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_branch_taken  = br_taken_r;
  assign out_branch_offset = br_off_r;
  assign out_out_valid     = oval_vld_r;
  assign out_out_value     = oval_r;

endmodule

`default_nettype wire

/* rtl/risc16_execute_unit.sv */
// Top level of the 16-bit execute unit: front end, queue, back end and data memory.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------------
//   in      | in_valid / in_stall  | command, dest/src_a/src_b index, immediate,
//           |                      | in_value
//   out     | out_valid / out_stall| branch_taken, branch_offset, out_valid, out_value
//
// The back end runs one word at a time over the register file and the single-port
// byte memory: ALU, compare, branch, OUT and STB words pass fetch and execute, LDB adds a
// byte read, ST a high-byte write, LD low and high byte reads; with MEM_BYTES not a power
// of two, memory words also pass an address step. After reset a clearing pass zeroes the
// memory with in_stall high. A two-word queue sits between front and back; out_stall holds
// the result register, then the back end, then the queue fills and raises in_stall.
`default_nettype none

module risc16_execute_unit #(
  parameter int MEM_BYTES = r16x_pkg::MEM_BYTES_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [r16x_pkg::CMD_W-1:0]        in_command,
  input  wire  [r16x_pkg::IDX_W-1:0]        in_dest_index,
  input  wire  [r16x_pkg::IDX_W-1:0]        in_src_a_index,
  input  wire  [r16x_pkg::IDX_W-1:0]        in_src_b_index,
  input  wire  signed [r16x_pkg::IMM_W-1:0] in_immediate,
  input  wire  signed [r16x_pkg::REG_W-1:0] in_in_value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              out_branch_taken,
  output logic signed [8:0]                 out_branch_offset,
  output logic                              out_out_valid,
  output logic signed [r16x_pkg::REG_W-1:0] out_out_value
);
  import r16x_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  dec_t          head;
  logic          head_vld;
  logic          pop;
  logic          mem_busy;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  r16x_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_dest_index  (in_dest_index),
    .in_src_a_index (in_src_a_index),
    .in_src_b_index (in_src_b_index),
    .in_immediate   (in_immediate),
    .in_in_value    (in_in_value),
    .hold           (mem_busy),
    .head           (head),
    .head_vld       (head_vld),
    .pop            (pop)
  );

  r16x_dmem #(
    .MEM_BYTES (MEM_BYTES),
    .AW        (AW)
  ) u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  r16x_back #(
    .MEM_BYTES (MEM_BYTES),
    .AW        (AW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .head_vld          (head_vld),
    .pop               (pop),
    .mem_we            (mem_we),
    .mem_addr          (mem_addr),
    .mem_wdata         (mem_wdata),
    .mem_rdata         (mem_rdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_branch_taken  (out_branch_taken),
    .out_branch_offset (out_branch_offset),
    .out_out_valid     (out_out_valid),
    .out_out_value     (out_out_value)
  );

endmodule

`default_nettype wire

/* sim/risc16_execute_unit_checker.sv */
// Checker for the 16-bit execute unit: predicts each result word and compares it.
`timescale 1ns / 100ps

module risc16_execute_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [4:0]  in_command,
  input  logic [2:0]  in_dest_index,
  input  logic [2:0]  in_src_a_index,
  input  logic [2:0]  in_src_b_index,
  input  logic [7:0]  in_immediate,
  input  logic [15:0] in_in_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_branch_taken,
  input  logic [8:0]  out_branch_offset,
  input  logic        out_out_valid,
  input  logic [15:0] out_out_value,
  output int          mismatch_count,
  output int          pending_results
);
  import r16x_pkg::*;

  typedef struct packed {
    logic        taken;
    logic [8:0]  offset;
    logic        shown;
    logic [15:0] shown_word;
  } exec_result_t;

  bit [15:0] reg_words [0:7];
  bit [7:0]  data_bytes [0:65535];
  exec_result_t exec_results_q[$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  function automatic exec_result_t execute_word(input op_t cmd, input logic [2:0] rd,
      input logic [2:0] ra, input logic [2:0] rb, input logic [7:0] imm,
      input logic [15:0] inval);
    exec_result_t res;
    logic [15:0] va, vb, imm_x, mag, addr, addr_hi;
    res     = '0;
    va      = reg_words[ra];
    vb      = reg_words[rb];
    imm_x   = {{8{imm[7]}}, imm};
    addr    = va + imm_x;
    addr_hi = addr + 16'd1;
    mag     = vb[15] ? -vb : vb;
    case (cmd)
      OP_AND:    reg_words[rd] = va & vb;
      OP_OR:     reg_words[rd] = va | vb;
      OP_XOR:    reg_words[rd] = va ^ vb;
      OP_NOT:    reg_words[rd] = ~va;
      OP_ADD:    reg_words[rd] = va + vb;
      OP_SUB:    reg_words[rd] = va - vb;
      OP_SHL: begin
        if (mag >= 16'd16) reg_words[rd] = '0;
        else if (vb[15]) reg_words[rd] = va >> mag;
        else reg_words[rd] = va << mag;
      end
      OP_CMPLT:  reg_words[rd] = {15'd0, $signed(va) < $signed(vb)};
      OP_CMPLE:  reg_words[rd] = {15'd0, $signed(va) <= $signed(vb)};
      OP_CMPEQ:  reg_words[rd] = {15'd0, va == vb};
      OP_CMPLTU: reg_words[rd] = {15'd0, va < vb};
      OP_CMPLEU: reg_words[rd] = {15'd0, va <= vb};
      OP_ADDI:   reg_words[rd] = va + imm_x;
      OP_LD:     reg_words[rd] = {data_bytes[addr_hi], data_bytes[addr]};
      OP_ST: begin
        data_bytes[addr]    = vb[7:0];
        data_bytes[addr_hi] = vb[15:8];
      end
      OP_LDB:    reg_words[rd] = {{8{data_bytes[addr][7]}}, data_bytes[addr]};
      OP_STB:    data_bytes[addr] = vb[7:0];
      OP_BZ, OP_BNZ: begin
        if ((cmd == OP_BZ) == (va == 16'd0)) begin
          res.taken  = 1'b1;
          res.offset = {imm, 1'b0};
        end
      end
      OP_MOVI:   reg_words[rd] = imm_x;
      OP_IN:     reg_words[rd] = inval;
      OP_OUT: begin
        res.shown      = 1'b1;
        res.shown_word = va;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (exec_results_q.size() == 0) begin
          $display("%0t: result word with nothing expected, got taken %b offset %h out %b %h",
                   $time, out_branch_taken, out_branch_offset, out_out_valid, out_out_value);
          mismatch_count++;
        end else begin
          want = exec_results_q.pop_front();
          check_field("branch_taken", 16'(want.taken), 16'(out_branch_taken));
          check_field("branch_offset", 16'(want.offset), 16'(out_branch_offset));
          check_field("out_valid", 16'(want.shown), 16'(out_out_valid));
          check_field("out_value", want.shown_word, out_out_value);
        end
      end
      if (in_valid && !in_stall)
        exec_results_q.push_back(execute_word(op_t'(in_command), in_dest_index,
                                              in_src_a_index, in_src_b_index,
                                              in_immediate, in_in_value));
      pending_results <= exec_results_q.size();
    end
  end

endmodule

/* sim/risc16_execute_unit_tb.sv */
// Testbench top for the 16-bit execute unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module risc16_execute_unit_tb;
  import r16x_pkg::*;

  localparam int IDLE_PCT     = 18;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 250000;
  localparam int RANDOM_WORDS = 1260;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_stall;
  logic [4:0]  in_command        = '0;
  logic [2:0]  in_dest_index     = '0;
  logic [2:0]  in_src_a_index    = '0;
  logic [2:0]  in_src_b_index    = '0;
  logic [7:0]  in_immediate      = '0;
  logic [15:0] in_in_value       = '0;
  logic        out_valid;
  logic        out_stall         = 1'b0;
  logic        out_branch_taken;
  logic [8:0]  out_branch_offset;
  logic        out_out_valid;
  logic [15:0] out_out_value;
  int          mismatch_count;
  int          pending_results;
  int          quiet_cycles      = 0;
  bit          idle_on           = 1'b1;
  bit          hold_req          = 1'b0;

  risc16_execute_unit u_top (.*);

  risc16_execute_unit_checker u_checker (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("risc16_execute_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input op_t cmd, input logic [2:0] rd, input logic [2:0] ra,
      input logic [2:0] rb, input logic [7:0] imm, input logic [15:0] value);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_dest_index  <= rd;
    in_src_a_index <= ra;
    in_src_b_index <= rb;
    in_immediate   <= imm;
    in_in_value    <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_word();
    int          pick;
    op_t         cmd;
    logic [2:0]  rd, ra, rb;
    logic [7:0]  imm;
    logic [15:0] value;
    pick  = $urandom_range(99);
    cmd   = op_t'($urandom_range(OP_OUT));
    if ($urandom_range(99) < 3)
      cmd = op_t'($urandom_range((1 << CMD_W) - 1, int'(OP_OUT) + 1));
    rd    = 3'($urandom);
    ra    = 3'($urandom);
    rb    = 3'($urandom);
    imm   = 8'($urandom);
    value = 16'($urandom);
    case (cmd)
      OP_LD, OP_ST, OP_LDB, OP_STB: begin
        if (pick < 70) ra = 3'd7;
      end
      OP_SHL: begin
        if (pick < 60) send_word(OP_MOVI, rb, 3'd0, 3'd0, 8'(int'($urandom_range(34)) - 17), '0);
      end
      OP_BZ, OP_BNZ: begin
        if (pick < 40) send_word(OP_SUB, ra, ra, ra, '0, '0);
      end
      OP_CMPLT, OP_CMPLE, OP_CMPEQ, OP_CMPLTU, OP_CMPLEU: begin
        if (pick < 30) rb = ra;
      end
      default: ;
    endcase
    send_word(cmd, rd, ra, rb, imm, value);
  endtask

  initial begin
    logic [15:0] base;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_word(OP_MOVI,   3'd1, 3'd0, 3'd0, 8'h7F, '0);
    send_word(OP_MOVI,   3'd2, 3'd0, 3'd0, 8'h80, '0);
    send_word(OP_IN,     3'd3, 3'd0, 3'd0, '0, 16'h8000);
    send_word(OP_IN,     3'd4, 3'd0, 3'd0, '0, 16'h7FFF);
    send_word(OP_IN,     3'd5, 3'd0, 3'd0, '0, 16'hFFFF);
    send_word(OP_AND,    3'd6, 3'd5, 3'd4, '0, '0);
    send_word(OP_OR,     3'd6, 3'd3, 3'd1, '0, '0);
    send_word(OP_XOR,    3'd6, 3'd5, 3'd4, '0, '0);
    send_word(OP_NOT,    3'd6, 3'd4, 3'd0, '0, '0);
    send_word(OP_ADD,    3'd6, 3'd4, 3'd4, '0, '0);
    send_word(OP_SUB,    3'd6, 3'd0, 3'd5, '0, '0);
    send_word(OP_MOVI,   3'd7, 3'd0, 3'd0, 8'd3, '0);
    send_word(OP_SHL,    3'd6, 3'd5, 3'd7, '0, '0);
    send_word(OP_MOVI,   3'd7, 3'd0, 3'd0, 8'hFD, '0);
    send_word(OP_SHL,    3'd6, 3'd3, 3'd7, '0, '0);
    send_word(OP_MOVI,   3'd7, 3'd0, 3'd0, 8'd16, '0);
    send_word(OP_SHL,    3'd6, 3'd5, 3'd7, '0, '0);
    send_word(OP_SHL,    3'd6, 3'd4, 3'd3, '0, '0);
    send_word(OP_CMPLT,  3'd6, 3'd3, 3'd4, '0, '0);
    send_word(OP_CMPLE,  3'd6, 3'd4, 3'd4, '0, '0);
    send_word(OP_CMPEQ,  3'd6, 3'd5, 3'd5, '0, '0);
    send_word(OP_CMPLTU, 3'd6, 3'd3, 3'd4, '0, '0);
    send_word(OP_CMPLEU, 3'd6, 3'd4, 3'd3, '0, '0);
    send_word(OP_ADDI,   3'd6, 3'd4, 3'd0, 8'd1, '0);
    send_word(OP_ST,     3'd0, 3'd5, 3'd4, 8'd0, '0);
    send_word(OP_LD,     3'd6, 3'd0, 3'd0, 8'hFF, '0);
    send_word(OP_LDB,    3'd6, 3'd5, 3'd0, 8'd0, '0);
    send_word(OP_STB,    3'd0, 3'd1, 3'd2, 8'h7F, '0);
    send_word(OP_LDB,    3'd6, 3'd1, 3'd0, 8'h7F, '0);
    send_word(OP_BZ,     3'd0, 3'd0, 3'd0, 8'h80, '0);
    send_word(OP_BZ,     3'd0, 3'd5, 3'd0, 8'h7F, '0);
    send_word(OP_BNZ,    3'd0, 3'd5, 3'd0, 8'h7F, '0);
    send_word(OP_BNZ,    3'd0, 3'd0, 3'd0, 8'h80, '0);
    send_word(OP_OUT,    3'd0, 3'd3, 3'd0, '0, '0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 300) hold_req = 1'b1;
      idle_on = !(n >= 600 && n < 900);
      if (n % 16 == 0) begin
        base = ($urandom_range(1) == 0) ? 16'($urandom_range(63))
                                        : (16'hFFC0 | 16'($urandom_range(63)));
        send_word(OP_IN, 3'd7, 3'd0, 3'd0, '0, base);
      end
      random_word();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("risc16_execute_unit_tb: clean");
    else
      $display("risc16_execute_unit_tb: errors");
    $finish;
  end

endmodule
